// ===== rtl/msiidr_pkg.sv =====
// types and constants for the msi interrupt domain register block
// shared by msi_interrupt_domain_registers_top and its testbench; no other dependencies
package msiidr_pkg;

    localparam int OFFSET_W = 14;
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int EIID_W   = 11;
    localparam int DOMCFG_W = 9;

    localparam logic [OFFSET_W-1:0] BASE_DOMCFG  = 14'h0000;
    localparam logic [OFFSET_W-1:0] BASE_SRCMODE = 14'h0004;
    localparam logic [OFFSET_W-1:0] ADDR_SETIP   = 14'h1CDC;
    localparam logic [OFFSET_W-1:0] BASE_TARGET  = 14'h3004;

    localparam int DOMCFG_IE_BIT = 8;
    localparam logic [DOMCFG_W-1:0] DOMCFG_MASK  = 9'h105;
    localparam logic [DATA_W-1:0]   DOMCFG_RDTOP = 32'h8000_0000;
    localparam logic [DATA_W-1:0]   TARGET_MASK  = 32'hFFFF_F7FF;

    localparam logic ACTION_READ  = 1'b0;
    localparam logic ACTION_WRITE = 1'b1;

    typedef struct packed {
        logic                action;
        logic [OFFSET_W-1:0] offset;
        logic [DATA_W-1:0]   write_data;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              msi_valid;
        logic [EIID_W-1:0] msi_eiid;
    } t_out_item;

endpackage

// ===== rtl/msi_interrupt_domain_registers_top.sv =====
// interrupt domain register block in msi delivery mode
// uses msiidr_pkg for the item structs and register map constants
//
// usage:
//   input channel (i_in_valid / o_in_stall / i_in_item) carries one bus access
//   per item: a read or a write at a byte offset. the output channel
//   (o_out_valid / i_out_stall / o_out_item) returns exactly one item per
//   access: read data, or zero read data plus an optional msi message for a
//   setipnum write.
//   source modes and target words live in two single-port-write memories with
//   a registered read port. an accepted access reads its entry at the accept
//   edge, the result is formed from the read data in the middle stage and held
//   in an output register. throughput is one access per cycle outside the
//   clearing pass and while the output is not stalled, set by the one read per
//   memory and cycle; writes land at the accept edge so a following access
//   sees them. after reset the block runs a clearing pass over every entry
//   that zeroes both memories; o_in_stall is high during that pass.
//   when the receiver stalls, the output item holds, the middle stage holds
//   one more access, and then o_in_stall rises until the output drains.
module msi_interrupt_domain_registers_top
    import msiidr_pkg::*;
#(
    parameter int SOURCE_COUNT = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW = (SOURCE_COUNT > 2) ? $clog2(SOURCE_COUNT) : 1;
    localparam logic [OFFSET_W:0] SPAN = (OFFSET_W+1)'((SOURCE_COUNT - 1) * 4);
    localparam logic [AW-1:0] LAST_IDX = AW'(SOURCE_COUNT - 1);

    typedef enum logic [2:0] {
        K_NONE,
        K_DOMCFG,
        K_MODE,
        K_TARGET,
        K_SETIP
    } t_kind;

    // memories
    logic [MODE_W-1:0] mem_mode   [SOURCE_COUNT];
    logic [DATA_W-1:0] mem_target [SOURCE_COUNT];

    logic                r_clr_busy;
    logic [AW-1:0]       r_clr_idx;
    logic [DOMCFG_W-1:0] r_domcfg;

    logic                r_s1_vld;
    t_kind               r_s1_kind;
    logic [DOMCFG_W-1:0] r_s1_domcfg;
    logic [MODE_W-1:0]   r_mode_q;
    logic [DATA_W-1:0]   r_target_q;

    logic      r_out_vld;
    t_out_item r_out;
    t_out_item n_out;

    logic in_acc;
    logic s1_adv;

    // decode
    logic [OFFSET_W-1:0] off_src;
    logic [OFFSET_W-1:0] off_tgt;
    logic [OFFSET_W-1:0] src_idx_w;
    logic [OFFSET_W-1:0] tgt_idx_w;
    logic                in_src;
    logic                in_tgt;
    logic                is_domcfg;
    logic                is_setip;
    logic                n_ok;
    logic [AW-1:0]       n_idx;
    logic [AW-1:0]       mode_ra;
    logic [AW-1:0]       target_ra;
    t_kind               kind;

    logic              mode_we;
    logic [AW-1:0]     mode_wa;
    logic [MODE_W-1:0] mode_wd;
    logic              target_we;
    logic [AW-1:0]     target_wa;
    logic [DATA_W-1:0] target_wd;

    assign s1_adv     = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_clr_busy || (r_s1_vld && !s1_adv);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign off_src   = i_in_item.offset - BASE_SRCMODE;
    assign off_tgt   = i_in_item.offset - BASE_TARGET;
    assign src_idx_w = 14'd1 + (off_src >> 2);
    assign tgt_idx_w = 14'd1 + (off_tgt >> 2);
    assign in_src    = (i_in_item.offset >= BASE_SRCMODE) && ({1'b0, off_src} < SPAN);
    assign in_tgt    = (i_in_item.offset >= BASE_TARGET) && ({1'b0, off_tgt} < SPAN);
    assign is_domcfg = (i_in_item.offset == BASE_DOMCFG);
    assign is_setip  = !is_domcfg && !in_src && !in_tgt && (i_in_item.offset == ADDR_SETIP);

    assign n_ok  = (i_in_item.write_data != '0)
                && (i_in_item.write_data < DATA_W'(SOURCE_COUNT));
    assign n_idx = i_in_item.write_data[AW-1:0];

    assign mode_ra   = in_src ? src_idx_w[AW-1:0] : n_idx;
    assign target_ra = in_tgt ? tgt_idx_w[AW-1:0] : n_idx;

    always_comb begin
        kind = K_NONE;
        if (i_in_item.action == ACTION_READ) begin
            if (is_domcfg) begin
                kind = K_DOMCFG;
            end else if (in_src) begin
                kind = K_MODE;
            end else if (in_tgt) begin
                kind = K_TARGET;
            end
        end else if (is_setip && n_ok && r_domcfg[DOMCFG_IE_BIT]) begin
            kind = K_SETIP;
        end
    end

    // write ports, shared between the clearing pass and register writes
    always_comb begin
        mode_we   = 1'b0;
        mode_wa   = mode_ra;
        mode_wd   = i_in_item.write_data[MODE_W-1:0];
        target_we = 1'b0;
        target_wa = target_ra;
        target_wd = i_in_item.write_data & TARGET_MASK;
        if (r_clr_busy) begin
            mode_we   = 1'b1;
            mode_wa   = r_clr_idx;
            mode_wd   = '0;
            target_we = 1'b1;
            target_wa = r_clr_idx;
            target_wd = '0;
        end else if (in_acc && i_in_item.action == ACTION_WRITE) begin
            mode_we   = !is_domcfg && in_src;
            target_we = !is_domcfg && !in_src && in_tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mode_we) begin
            mem_mode[mode_wa] <= mode_wd;
        end
        if (in_acc) begin
            r_mode_q <= mem_mode[mode_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (target_we) begin
            mem_target[target_wa] <= target_wd;
        end
        if (in_acc) begin
            r_target_q <= mem_target[target_ra];
        end
    end

    // clearing pass, domain config and the middle stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_domcfg   <= '0;
            r_s1_vld   <= 1'b0;
            r_s1_kind  <= K_NONE;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_IDX) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_acc && i_in_item.action == ACTION_WRITE && is_domcfg) begin
                r_domcfg <= i_in_item.write_data[DOMCFG_W-1:0] & DOMCFG_MASK;
            end
            if (in_acc) begin
                r_s1_vld  <= 1'b1;
                r_s1_kind <= kind;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_domcfg <= r_domcfg;
        end
    end

    always_comb begin
        n_out = '0;
        case (r_s1_kind)
            K_DOMCFG: n_out.read_data = DOMCFG_RDTOP | DATA_W'(r_s1_domcfg);
            K_MODE:   n_out.read_data = DATA_W'(r_mode_q);
            K_TARGET: n_out.read_data = r_target_q;
            K_SETIP: begin
                if (r_mode_q != '0) begin
                    n_out.msi_valid = 1'b1;
                    n_out.msi_eiid  = r_target_q[EIID_W-1:0];
                end
            end
            default: n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // checks
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !in_acc)
        else $error("item accepted during clearing pass");

    a_msi_zero_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.msi_valid) |-> (r_out.read_data == '0))
        else $error("msi item carries read data");

    a_eiid_only_with_msi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.msi_valid) |-> (r_out.msi_eiid == '0))
        else $error("eiid set without msi");

    a_s1_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_adv) |=> r_s1_vld)
        else $error("middle stage item dropped");

endmodule

// ===== sim/msi_interrupt_domain_registers_top_tb.sv =====
// self-checking testbench for msi_interrupt_domain_registers_top
// drives bus reads and writes, predicts register contents and msi messages
// depends on msiidr_pkg and the top level only
module msi_interrupt_domain_registers_top_tb;
    import msiidr_pkg::*;

    localparam int SOURCE_COUNT = 64;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1900;
    localparam int TAIL_CYCLES  = 20;

    typedef struct {
        t_in_item acc;
        bit       drain;
    } t_pending_access;

    logic      i_clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // predicted register contents
    logic [DOMCFG_W-1:0] dom_cfg;
    logic [MODE_W-1:0]   mode_mem   [SOURCE_COUNT];
    logic [DATA_W-1:0]   target_mem [SOURCE_COUNT];

    t_pending_access access_q[$];
    t_out_item       resp_q[$];

    int unsigned n_sent      = 0;
    int unsigned n_recv      = 0;
    int unsigned mismatches  = 0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;
    int unsigned calm_in     = 0;
    int unsigned calm_out    = 0;
    int unsigned idle_cycles = 0;

    msi_interrupt_domain_registers_top #(
        .SOURCE_COUNT(SOURCE_COUNT)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (mismatches < 40) begin
            $display("mismatch %s: got %h, want %h", what, got, want);
        end
        mismatches = mismatches + 1;
    endtask

    // 0 when off is outside the region, else the source index
    function automatic int unsigned region_index(input logic [OFFSET_W-1:0] off,
                                                 input logic [OFFSET_W-1:0] base);
        if (off < base || int'(off) - int'(base) >= (SOURCE_COUNT - 1) * 4) begin
            return 0;
        end
        return 1 + (int'(off) - int'(base)) / 4;
    endfunction

    function automatic t_out_item regs_access(input t_in_item acc);
        t_out_item         res;
        int unsigned       si;
        int unsigned       ti;
        logic [DATA_W-1:0] n;
        res = '0;
        si  = region_index(acc.offset, BASE_SRCMODE);
        ti  = region_index(acc.offset, BASE_TARGET);
        n   = acc.write_data;
        if (acc.action == ACTION_READ) begin
            if (acc.offset == BASE_DOMCFG) begin
                res.read_data = DOMCFG_RDTOP | DATA_W'(dom_cfg);
            end else if (si != 0) begin
                res.read_data = DATA_W'(mode_mem[si]);
            end else if (ti != 0) begin
                res.read_data = target_mem[ti];
            end
        end else begin
            if (acc.offset == BASE_DOMCFG) begin
                dom_cfg = acc.write_data[DOMCFG_W-1:0] & DOMCFG_MASK;
            end else if (si != 0) begin
                mode_mem[si] = acc.write_data[MODE_W-1:0];
            end else if (ti != 0) begin
                target_mem[ti] = acc.write_data & TARGET_MASK;
            end else if (acc.offset == ADDR_SETIP) begin
                if (n != 0 && n < SOURCE_COUNT && mode_mem[n] != 0
                        && dom_cfg[DOMCFG_IE_BIT]) begin
                    res.msi_valid = 1'b1;
                    res.msi_eiid  = target_mem[n][EIID_W-1:0];
                end
            end
        end
        return res;
    endfunction

    // idle length: mostly none or short, a few long, now and then a calm stretch
    function automatic int unsigned pick_idle(inout int unsigned calm);
        int unsigned r;
        if (calm != 0) begin
            calm = calm - 1;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 5) begin
            calm = $urandom_range(50, 200);
            return 0;
        end
        if (r < 550) return 0;
        if (r < 900) return $urandom_range(1, 3);
        if (r < 985) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_access(input logic action, input logic [OFFSET_W-1:0] off,
                              input logic [DATA_W-1:0] data, input bit drain);
        t_pending_access p;
        p.acc.action     = action;
        p.acc.offset     = off;
        p.acc.write_data = data;
        p.drain          = drain;
        access_q.push_back(p);
    endtask

    // offset of a random source in a region, low two bits random
    function automatic logic [OFFSET_W-1:0] region_offset(input logic [OFFSET_W-1:0] base);
        int unsigned idx;
        idx = $urandom_range(1, SOURCE_COUNT - 1);
        return OFFSET_W'(int'(base) + (idx - 1) * 4 + $urandom_range(0, 3));
    endfunction

    task automatic add_random_access(input bit drain);
        int unsigned       kind;
        int unsigned       r;
        logic              act;
        logic [DATA_W-1:0] data;
        logic [OFFSET_W-1:0] off;
        kind = $urandom_range(0, 99);
        act  = $urandom_range(0, 1) ? ACTION_WRITE : ACTION_READ;
        data = $urandom();
        if (kind < 10) begin
            // keep ie set most of the time so setipnum writes get through
            off = BASE_DOMCFG;
            data[DOMCFG_IE_BIT] = ($urandom_range(0, 3) != 0);
        end else if (kind < 35) begin
            off = region_offset(BASE_SRCMODE);
        end else if (kind < 60) begin
            off = region_offset(BASE_TARGET);
        end else if (kind < 85) begin
            off = ADDR_SETIP;
            act = ($urandom_range(0, 9) != 0) ? ACTION_WRITE : ACTION_READ;
            r   = $urandom_range(0, 99);
            if (r < 80) data = $urandom_range(1, SOURCE_COUNT - 1);
            else if (r < 88) data = '0;
            else if (r < 96) data = $urandom_range(SOURCE_COUNT, SOURCE_COUNT + 100);
        end else if (kind < 92) begin
            // around the region edges
            r   = $urandom_range(0, 1);
            off = OFFSET_W'((r ? int'(BASE_TARGET) : int'(BASE_SRCMODE))
                  + (SOURCE_COUNT - 1) * 4 + $urandom_range(0, 8) - 8);
            if ($urandom_range(0, 3) == 0) begin
                off = OFFSET_W'((r ? int'(BASE_TARGET) : int'(BASE_SRCMODE))
                      - $urandom_range(1, 4));
            end
        end else begin
            off = OFFSET_W'($urandom_range(0, (1 << OFFSET_W) - 1));
        end
        add_access(act, off, data, drain);
    endtask

    // sender
    always @(posedge i_clk) begin
        logic        nxt_valid;
        int unsigned gap_now;
        int unsigned sent_now;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            nxt_valid = in_valid;
            gap_now   = gap_left;
            sent_now  = n_sent;
            if (in_valid && !o_in_stall) begin
                resp_q.push_back(regs_access(in_item));
                sent_now  = n_sent + 1;
                n_sent   <= sent_now;
                nxt_valid = 1'b0;
                gap_now   = pick_idle(calm_in);
            end
            if (!nxt_valid) begin
                if (gap_now != 0) begin
                    gap_now = gap_now - 1;
                end else if (access_q.size() != 0
                        && (!access_q[0].drain || sent_now == n_recv)) begin
                    in_item <= access_q[0].acc;
                    void'(access_q.pop_front());
                    nxt_valid = 1'b1;
                end
            end
            gap_left <= gap_now;
            in_valid <= nxt_valid;
        end
    end

    // receiver
    always @(posedge i_clk) begin
        t_out_item   want;
        int unsigned s;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                n_recv <= n_recv + 1;
                if (resp_q.size() == 0) begin
                    report_mismatch("unexpected item", o_out_item.read_data, '0);
                end else begin
                    want = resp_q.pop_front();
                    if (o_out_item.read_data !== want.read_data)
                        report_mismatch("read_data", o_out_item.read_data, want.read_data);
                    if (o_out_item.msi_valid !== want.msi_valid)
                        report_mismatch("msi_valid", DATA_W'(o_out_item.msi_valid),
                                        DATA_W'(want.msi_valid));
                    if (o_out_item.msi_eiid !== want.msi_eiid)
                        report_mismatch("msi_eiid", DATA_W'(o_out_item.msi_eiid),
                                        DATA_W'(want.msi_eiid));
                end
            end
            if (stall_left != 0) begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                s = pick_idle(calm_out);
                out_stall  <= (s != 0);
                stall_left <= (s != 0) ? s - 1 : 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        dom_cfg = '0;
        foreach (mode_mem[i]) begin
            mode_mem[i]   = '0;
            target_mem[i] = '0;
        end

        add_access(ACTION_READ,  BASE_DOMCFG, 32'hFFFF_FFFF, 1'b0);
        add_access(ACTION_READ,  BASE_SRCMODE, 32'h0, 1'b0);
        add_access(ACTION_WRITE, BASE_DOMCFG, 32'hFFFF_FFFF, 1'b0);
        add_access(ACTION_READ,  BASE_DOMCFG, 32'h0, 1'b0);
        add_access(ACTION_WRITE, BASE_SRCMODE, 32'hFFFF_FFFF, 1'b0);
        add_access(ACTION_WRITE, 14'h00FC, 32'h0000_0002, 1'b0);
        add_access(ACTION_READ,  14'h00FF, 32'h0, 1'b0);
        add_access(ACTION_WRITE, BASE_TARGET, 32'hFFFF_FFFF, 1'b0);
        add_access(ACTION_READ,  14'h3007, 32'h0, 1'b0);
        add_access(ACTION_WRITE, 14'h30FC, 32'h0000_0ABC, 1'b0);
        add_access(ACTION_WRITE, ADDR_SETIP, 32'd1, 1'b0);
        add_access(ACTION_WRITE, ADDR_SETIP, SOURCE_COUNT - 1, 1'b0);
        // out of range, inactive source and a read of the trigger
        add_access(ACTION_WRITE, ADDR_SETIP, 32'd0, 1'b0);
        add_access(ACTION_WRITE, ADDR_SETIP, SOURCE_COUNT, 1'b0);
        add_access(ACTION_WRITE, ADDR_SETIP, 32'hFFFF_FFFF, 1'b0);
        add_access(ACTION_WRITE, ADDR_SETIP, 32'd2, 1'b0);
        add_access(ACTION_READ,  ADDR_SETIP, 32'd1, 1'b0);
        // unmapped holes and the end of the space
        add_access(ACTION_READ,  14'h0100, 32'h0, 1'b0);
        add_access(ACTION_READ,  14'h3100, 32'h0, 1'b0);
        add_access(ACTION_READ,  14'h0002, 32'h0, 1'b0);
        add_access(ACTION_WRITE, 14'h3FFF, 32'hFFFF_FFFF, 1'b0);
        add_access(ACTION_READ,  14'h3FFF, 32'h0, 1'b0);
        // ie clear blocks the message, then ie back on
        add_access(ACTION_WRITE, BASE_DOMCFG, 32'h0, 1'b0);
        add_access(ACTION_WRITE, ADDR_SETIP, 32'd1, 1'b0);
        add_access(ACTION_WRITE, BASE_DOMCFG, 32'h0000_0100, 1'b1);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            add_random_access(i % 300 == 299);
        end

        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;

        @(posedge i_clk);
        // sample between edges so the driver and monitor updates have settled
        while (access_q.size() != 0 || in_valid || n_recv != n_sent) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (resp_q.size() != 0) begin
            report_mismatch("leftover expectations", resp_q.size(), '0);
        end
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/msiidr_pkg.sv
rtl/msi_interrupt_domain_registers_top.sv
sim/msi_interrupt_domain_registers_top_tb.sv
